FILE: design/message_id_check_and_hash_unit_assert.svh
// Assertion macros for the message identifier check and hash unit.
`ifndef MESSAGE_ID_CHECK_AND_HASH_UNIT_ASSERT_SVH
`define MESSAGE_ID_CHECK_AND_HASH_UNIT_ASSERT_SVH

// Checked outside reset.
`define MIDH_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define MIDH_ASSERT_ALL(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/midh_pkg.sv
`default_nettype none
package midh_pkg;

   localparam int HASH_BUCKETS_DEFAULT = 2053;

   localparam logic [7:0] CHAR_LT       = 8'h3C;
   localparam logic [7:0] CHAR_GT       = 8'h3E;
   localparam logic [7:0] CHAR_AT       = 8'h40;
   localparam logic [7:0] CHAR_NUL      = 8'h00;
   localparam logic [7:0] CHAR_PRINT_LO = 8'h21;
   localparam logic [7:0] CHAR_PRINT_HI = 8'h7E;

   localparam logic [1:0] BODY_LEN_MIN = 2'd3;

   typedef enum logic [1:0] {
      PHASE_BODY   = 2'd0,
      PHASE_CLOSED = 2'd1,
      PHASE_FAILED = 2'd2
   } scan_phase_type;

endpackage
`default_nettype wire

FILE: design/message_id_check_and_hash_unit.sv
// Message identifier check and hash unit.
// Input channel (req_*): one identifier byte per transaction, req_is_last on
// the final byte. Result channel (rsp_*): one transaction per identifier,
// carrying rsp_id_valid (angle-bracket form with '@' ok) and rsp_bucket (hash of the
// bytes after the first, stopped at '@' or a zero byte, modulo HASH_BUCKETS,
// low 12 bits).
// Throughput: one byte per cycle while req_stall is low; identifiers may follow back to back.
// The verdict and hash of the last byte are registered before the modulo.
// The modulo runs in a 4-stage pipeline: split reciprocal multiply, sum and
// shift, multiply-back and subtract, then one final compare and subtract.
// Scan state updates as each byte is accepted and returns to its initial
// state after the last byte.
// Reset (synchronous, active high) clears the scan state and empties the
// pipeline. When rsp_stall holds a result, the pipeline fills behind it and
// then req_stall rises; non-last bytes are stalled too while the first
// stage is blocked.
`default_nettype none
`include "message_id_check_and_hash_unit_assert.svh"
module message_id_check_and_hash_unit
   import midh_pkg::*;
#(
   parameter int HASH_BUCKETS = HASH_BUCKETS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_byte,
   input  wire logic        req_is_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_id_valid,
   output logic [11:0]      rsp_bucket
);

   localparam int CW      = $clog2(HASH_BUCKETS);
   localparam int K       = 32 + CW;
   localparam int RW      = CW + 1;
   localparam longint unsigned RECIP = (64'd1 << K) / HASH_BUCKETS;
   localparam logic [16:0] RECIP_LO = 17'(RECIP);
   localparam logic [15:0] RECIP_HI = 16'(RECIP >> 17);
   localparam logic [RW-1:0] NBUCK  = RW'(HASH_BUCKETS);

   // scan state
   logic           first_ff, first_in;
   scan_phase_type phase_ff, phase_in;
   logic [1:0]     blen_ff, blen_in;
   logic           at_ff, at_in;
   logic           stop_ff, stop_in;
   logic [31:0]    hash_ff, hash_in;
   logic           ok_in;

   // pipeline
   logic           v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic           rdy0, rdy1, rdy2, rdy3, rdy4;
   logic           ok0_ff, ok1_ff, ok2_ff, ok3_ff, ok4_ff;
   logic [31:0]    h0_ff, h1_ff, h2_ff;
   logic [48:0]    plo_ff;
   logic [47:0]    phi_ff;
   logic [31:0]    q_ff;
   logic [64:0]    prod;
   logic [31:0]    diff;
   logic [RW-1:0]  rest_ff;
   logic [RW-1:0]  rem_in, rem_ff;

   logic           accept;
   logic [7:0]     b;

   assign rdy4      = !v4_ff || !rsp_stall;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign rdy0      = !v0_ff || rdy1;
   assign req_stall = !rdy0;
   assign accept    = req_valid && rdy0;
   assign b         = req_char_byte;

   // next scan state
   always_comb begin
      first_in = first_ff;
      phase_in = phase_ff;
      blen_in  = blen_ff;
      at_in    = at_ff;
      stop_in  = stop_ff;
      hash_in  = hash_ff;
      if (first_ff) begin
         first_in = 1'b0;
         if (b == CHAR_LT) begin
            blen_in = 2'd1;
         end else begin
            phase_in = PHASE_FAILED;
         end
      end else begin
         if (!stop_ff) begin
            if (b == CHAR_AT || b == CHAR_NUL) begin
               stop_in = 1'b1;
            end else begin
               hash_in = {hash_ff[30:0], 1'b0} ^ {24'd0, b};
            end
         end
         unique case (phase_ff)
            PHASE_BODY: begin
               if (b == CHAR_GT) begin
                  phase_in = PHASE_CLOSED;
               end else if (b >= CHAR_PRINT_LO && b <= CHAR_PRINT_HI) begin
                  if (b == CHAR_AT) begin
                     at_in = 1'b1;
                  end
                  if (blen_ff < BODY_LEN_MIN) begin
                     blen_in = blen_ff + 2'd1;
                  end
               end else begin
                  phase_in = PHASE_FAILED;
               end
            end
            PHASE_CLOSED: phase_in = PHASE_FAILED;
            PHASE_FAILED: phase_in = PHASE_FAILED;
            default:      phase_in = PHASE_FAILED;
         endcase
      end
   end

   // verdict from the updated state
   assign ok_in = (phase_in == PHASE_CLOSED) && at_in && (blen_in >= BODY_LEN_MIN);

   always_ff @(posedge clock) begin
      if (reset || (accept && req_is_last)) begin
         first_ff <= 1'b1;
         phase_ff <= PHASE_BODY;
         blen_ff  <= 2'd0;
         at_ff    <= 1'b0;
         stop_ff  <= 1'b0;
         hash_ff  <= 32'd0;
      end else if (accept) begin
         first_ff <= first_in;
         phase_ff <= phase_in;
         blen_ff  <= blen_in;
         at_ff    <= at_in;
         stop_ff  <= stop_in;
         hash_ff  <= hash_in;
      end
   end

   // modulo pipeline
   assign prod   = 65'(plo_ff) + (65'(phi_ff) << 17);
   assign diff   = h2_ff - 32'(q_ff * 32'(HASH_BUCKETS));
   assign rem_in = (rest_ff >= NBUCK) ? (rest_ff - NBUCK) : rest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= accept && req_is_last;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy0) begin
         h0_ff  <= hash_in;
         ok0_ff <= ok_in;
      end
      if (rdy1) begin
         plo_ff <= 49'(h0_ff) * 49'(RECIP_LO);
         phi_ff <= 48'(h0_ff) * 48'(RECIP_HI);
         h1_ff  <= h0_ff;
         ok1_ff <= ok0_ff;
      end
      if (rdy2) begin
         q_ff   <= 32'(prod >> K);
         h2_ff  <= h1_ff;
         ok2_ff <= ok1_ff;
      end
      if (rdy3) begin
         rest_ff <= RW'(diff);
         ok3_ff  <= ok2_ff;
      end
      if (rdy4) begin
         rem_ff <= rem_in;
         ok4_ff <= ok3_ff;
      end
   end

   assign rsp_valid    = v4_ff;
   assign rsp_id_valid = ok4_ff;
   assign rsp_bucket   = 12'(rem_ff);

   `MIDH_ASSERT_RST(a_rem_range, clock, reset, v4_ff |-> (rem_ff < NBUCK), "bucket out of range")
   `MIDH_ASSERT_RST(a_est_range, clock, reset,
      v2_ff |-> (diff < 32'(2 * HASH_BUCKETS)), "remainder estimate too large")
   `MIDH_ASSERT_RST(a_no_push, clock, reset,
      (accept && !req_is_last) |=> !v0_ff, "non-last byte entered pipeline")
   `MIDH_ASSERT_RST(a_restart, clock, reset,
      (accept && req_is_last) |=> (first_ff && hash_ff == 32'd0), "scan state not restarted")
   `MIDH_ASSERT_ALL(a_reset, clock, reset |=> (!rsp_valid && first_ff), "reset did not clear")

endmodule
`default_nettype wire

FILE: tb/sv/message_id_check_and_hash_unit_checker.sv
`default_nettype none
module message_id_check_and_hash_unit_checker
   import midh_pkg::*;
#(
   parameter int HASH_BUCKETS = HASH_BUCKETS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_char_byte,
   input  wire logic        req_is_last,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_id_valid,
   input  wire logic [11:0] rsp_bucket,
   output int               error_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        id_ok;
      logic [11:0] bucket;
   } id_verdict_type;

   id_verdict_type pending_verdicts[$];

   logic           first_byte;
   scan_phase_type phase;
   logic [1:0]     body_len;
   logic           at_seen;
   logic           hash_done;
   logic [31:0]    id_hash;

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   task automatic clear_scan();
      first_byte = 1'b1;
      phase      = PHASE_BODY;
      body_len   = 2'd0;
      at_seen    = 1'b0;
      hash_done  = 1'b0;
      id_hash    = 32'd0;
   endtask

   task automatic absorb_id_byte(input logic [7:0] b, input logic last);
      id_verdict_type v;
      logic [31:0]    div;
      if (first_byte) begin
         first_byte = 1'b0;
         if (b == CHAR_LT)
            body_len = 2'd1;
         else
            phase = PHASE_FAILED;
      end else begin
         if (!hash_done) begin
            if (b == CHAR_AT || b == CHAR_NUL)
               hash_done = 1'b1;
            else
               id_hash = (id_hash << 1) ^ {24'd0, b};
         end
         if (phase == PHASE_BODY) begin
            if (b == CHAR_GT) begin
               phase = PHASE_CLOSED;
            end else if (b >= CHAR_PRINT_LO && b <= CHAR_PRINT_HI) begin
               if (b == CHAR_AT)
                  at_seen = 1'b1;
               if (body_len < BODY_LEN_MIN)
                  body_len = body_len + 2'd1;
            end else begin
               phase = PHASE_FAILED;
            end
         end else if (phase == PHASE_CLOSED) begin
            phase = PHASE_FAILED;
         end
      end
      if (last) begin
         div      = (HASH_BUCKETS == 0) ? 32'd1 : 32'(HASH_BUCKETS);
         v.id_ok  = (phase == PHASE_CLOSED) && at_seen && (body_len >= BODY_LEN_MIN);
         v.bucket = 12'(id_hash % div);
         pending_verdicts.push_back(v);
         clear_scan();
      end
   endtask

   always @(posedge clock) begin
      id_verdict_type exp_v;
      if (reset) begin
         pending_verdicts.delete();
         clear_scan();
      end else begin
         if (req_valid && !req_stall)
            absorb_id_byte(req_char_byte, req_is_last);
         if (rsp_valid && !rsp_stall) begin
            if (pending_verdicts.size() == 0) begin
               $display("%0t: unexpected transaction id_valid=%0b bucket=%0d",
                        $time, rsp_id_valid, rsp_bucket);
               error_count++;
            end else begin
               exp_v = pending_verdicts.pop_front();
               if (rsp_id_valid !== exp_v.id_ok) begin
                  $display("%0t: id_valid mismatch expected=%0b actual=%0b",
                           $time, exp_v.id_ok, rsp_id_valid);
                  error_count++;
               end
               if (rsp_bucket !== exp_v.bucket) begin
                  $display("%0t: bucket mismatch expected=%0d actual=%0d",
                           $time, exp_v.bucket, rsp_bucket);
                  error_count++;
               end
            end
         end
      end
      pending_count = pending_verdicts.size();
   end

endmodule
`default_nettype wire

FILE: tb/sv/message_id_check_and_hash_unit_tb.sv
`default_nettype none
module message_id_check_and_hash_unit_tb
   import midh_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_BYTES  = 330;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_byte = 8'd0;
   logic        req_is_last   = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic        rsp_id_valid;
   logic [11:0] rsp_bucket;

   int          error_count;
   int          pending_count;
   int          req_idle_pct  = 0;
   int          rsp_idle_pct  = 0;
   int          bytes_sent    = 0;
   int          cycle_count   = 0;
   logic [7:0]  frame_q[$];

   message_id_check_and_hash_unit u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_byte (req_char_byte),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_id_valid  (rsp_id_valid),
      .rsp_bucket    (rsp_bucket)
   );

   message_id_check_and_hash_unit_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_byte (req_char_byte),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_id_valid  (rsp_id_valid),
      .rsp_bucket    (rsp_bucket),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   function automatic logic [7:0] body_char();
      logic [7:0] c;
      c = 8'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
      while (c == CHAR_GT || c == CHAR_AT)
         c = 8'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
      return c;
   endfunction

   function automatic logic [7:0] noise_char();
      case ($urandom_range(7))
         0:       return CHAR_LT;
         1:       return CHAR_GT;
         2:       return CHAR_AT;
         3:       return CHAR_NUL;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_frame();
      for (int i = 0; i < frame_q.size(); i++) begin
         while ($urandom_range(99) < req_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid     <= 1'b1;
         req_char_byte <= frame_q[i];
         req_is_last   <= (i == frame_q.size() - 1);
         do @(posedge clock); while (req_stall);
         bytes_sent++;
      end
   endtask

   task automatic build_random_frame();
      int kind;
      int body_cnt;
      int at_pos;
      int n;
      kind     = $urandom_range(99);
      body_cnt = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 10);
      frame_q.delete();
      if (kind < 75) begin
         frame_q.push_back(CHAR_LT);
         repeat (body_cnt) frame_q.push_back(body_char());
         if ($urandom_range(9) != 0) begin
            at_pos = $urandom_range(1, frame_q.size());
            frame_q.insert(at_pos, CHAR_AT);
         end
         frame_q.push_back(CHAR_GT);
         if (kind >= 60) begin
            // broken form: corrupt one byte or trail bytes past the close
            if ($urandom_range(1) == 0)
               frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom_range(255));
            else
               repeat ($urandom_range(1, 3)) frame_q.push_back(noise_char());
         end
      end else begin
         n = $urandom_range(1, 8);
         repeat (n) frame_q.push_back(noise_char());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      frame_q = '{CHAR_LT, "a", CHAR_AT, "b", CHAR_GT};
      send_frame();
      frame_q = '{"x"};
      send_frame();
      frame_q = '{CHAR_LT};
      send_frame();
      frame_q = '{CHAR_LT, "b", CHAR_GT, CHAR_GT};
      send_frame();
      frame_q = '{CHAR_LT, CHAR_NUL, CHAR_AT, CHAR_GT};
      send_frame();
      frame_q = '{CHAR_LT, 8'hFF, CHAR_AT, CHAR_GT};
      send_frame();
      frame_q = '{CHAR_LT, CHAR_AT, CHAR_GT};
      send_frame();

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               req_idle_pct = 36;
               rsp_idle_pct = 47;
            end
            1: begin
               req_idle_pct = 47;
               rsp_idle_pct = 36;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         while (bytes_sent < (p + 1) * PHASE_BYTES) begin
            build_random_frame();
            send_frame();
         end
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
`default_nettype wire

FILE: message_id_check_and_hash_unit.f
+incdir+design
design/midh_pkg.sv
design/message_id_check_and_hash_unit.sv
tb/sv/message_id_check_and_hash_unit_checker.sv
tb/sv/message_id_check_and_hash_unit_tb.sv
